@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hduart_pkg.sv @@
// shared types, constants and helpers for the half-duplex serial link controller
// no dependencies
package hduart_pkg;

	localparam int FIFO_DEPTH = 64;
	localparam int IDX_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int FILL_W     = 7;

	// receiver status bits for frame, overrun and parity errors
	localparam logic [7:0] ERR_MASK = 8'h1C;
	localparam logic [7:0] KEY_NONE = 8'h00;

	typedef enum logic [2:0] {
		ACT_SEND  = 3'd0,
		ACT_TXE   = 3'd1,
		ACT_TXC   = 3'd2,
		ACT_FRAME = 3'd3,
		ACT_KEY   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		MODE_RECV  = 2'd0,
		MODE_SEND  = 2'd1,
		MODE_DRAIN = 2'd2
	} mode_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       tx_ninth_bit;
		logic [7:0] rx_byte;
		logic [7:0] rx_status;
		logic       rx_ninth_bit;
	} ev_item_t;

	typedef struct packed {
		logic              tx_valid;
		logic [8:0]        tx_word;
		logic              send_dropped;
		logic              key_valid;
		logic [7:0]        key_code;
		logic [1:0]        line_mode;
		logic [FILL_W-1:0] fill_level;
	} res_item_t;

	// controller to datapath
	typedef struct packed {
		logic exec;      // event word accepted this cycle
		logic load_pop;  // ring read data is ready, emit popped word
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;  // result register holds a word
		logic pop_hit;   // current event word pops the ring
	} dp_status_t;

	// low bits of the word count, zero extended for small depths
	function automatic logic [FILL_W-1:0] fill_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+FILL_W-1:0] wide;
		wide = {{FILL_W{1'b0}}, cnt};
		return wide[FILL_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

@@ rtl/hduart_ev_if.sv @@
// valid/ready channel carrying one event word
// depends on hduart_pkg
interface hduart_ev_if;
	import hduart_pkg::*;

	logic     valid;
	logic     ready;
	ev_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hduart_res_if.sv @@
// valid/ready channel carrying one result word
// depends on hduart_pkg
interface hduart_res_if;
	import hduart_pkg::*;

	logic      valid;
	logic      ready;
	res_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hduart_ctrl.sv @@
// controller: accepts event words and sequences the ring read for a pop
// depends on hduart_pkg and assert_macros.svh
`include "assert_macros.svh"

module hduart_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ev_valid,
	output logic                   ev_ready,
	input  logic                   res_ready,
	input  hduart_pkg::dp_status_t st,
	output hduart_pkg::dp_cmd_t    cmd
);
	import hduart_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		ev_ready     = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ev_ready = !st.out_full || res_ready;
				cmd.exec = ev_valid && ev_ready;
				if (cmd.exec && st.pop_hit) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load_pop = 1'b1;
				state_nx     = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// the result slot was free or drained when the pop was taken
	`ASSERT_IMPLIES(a_read_slot_free, state_q == ST_READ, !st.out_full, "pop fetch with result slot busy")
	`ASSERT_NEXT(a_pop_fetch, cmd.exec && st.pop_hit, state_q == ST_READ, "pop not followed by ring fetch")

endmodule

@@ rtl/hduart_dp.sv @@
// datapath: transmit ring memory, pointers, line mode, key latch, result register
// depends on hduart_pkg and assert_macros.svh
`include "assert_macros.svh"

module hduart_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hduart_pkg::ev_item_t   ev,
	input  hduart_pkg::dp_cmd_t    cmd,
	output hduart_pkg::dp_status_t st,
	output logic                   res_valid,
	input  logic                   res_ready,
	output hduart_pkg::res_item_t  res
);
	import hduart_pkg::*;

	logic [8:0]       mem [FIFO_DEPTH];
	logic [8:0]       rd_data_q;
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q, wr_nx, rd_nx;
	logic [CNT_W-1:0] cnt_q, cnt_nx;
	mode_t            mode_q, mode_nx;
	logic [7:0]       latch_byte_q, latch_byte_nx;
	logic             latch_full_q, latch_full_nx;
	logic             full, push, pop_hit;
	logic             res_valid_q;
	res_item_t        res_q, res_nx, pop_res;

	assign full = (cnt_q == CNT_W'(FIFO_DEPTH));

	always_comb begin
		cnt_nx        = cnt_q;
		mode_nx       = mode_q;
		wr_nx         = wr_idx_q;
		rd_nx         = rd_idx_q;
		latch_byte_nx = latch_byte_q;
		latch_full_nx = latch_full_q;
		push          = 1'b0;
		pop_hit       = 1'b0;
		res_nx        = '0;
		case (ev.action)
			ACT_SEND: begin
				if (!full) begin
					push   = 1'b1;
					cnt_nx = cnt_q + 1'b1;
					wr_nx  = next_slot(wr_idx_q);
				end else begin
					res_nx.send_dropped = 1'b1;
				end
				mode_nx = MODE_SEND;
			end
			ACT_TXE: begin
				if (mode_q == MODE_SEND) begin
					if (cnt_q != '0) begin
						pop_hit = 1'b1;
						cnt_nx  = cnt_q - 1'b1;
						rd_nx   = next_slot(rd_idx_q);
					end else begin
						mode_nx = MODE_DRAIN;
					end
				end
			end
			ACT_TXC: begin
				if (mode_q == MODE_DRAIN) begin
					mode_nx = MODE_RECV;
				end
			end
			ACT_FRAME: begin
				if (mode_q == MODE_RECV && (ev.rx_status & ERR_MASK) == 8'h00
						&& !ev.rx_ninth_bit) begin
					latch_byte_nx = ev.rx_byte;
					latch_full_nx = 1'b1;
				end
			end
			ACT_KEY: begin
				if (latch_full_q) begin
					res_nx.key_valid = 1'b1;
					res_nx.key_code  = latch_byte_q;
					latch_byte_nx    = KEY_NONE;
					latch_full_nx    = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res_nx.line_mode  = mode_nx;
		res_nx.fill_level = fill_of(cnt_nx);
	end

	always_comb begin
		pop_res            = '0;
		pop_res.tx_valid   = 1'b1;
		pop_res.tx_word    = rd_data_q;
		pop_res.line_mode  = mode_q;
		pop_res.fill_level = fill_of(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			mode_q       <= MODE_DRAIN;
			latch_byte_q <= KEY_NONE;
			latch_full_q <= 1'b0;
		end else if (cmd.exec) begin
			cnt_q        <= cnt_nx;
			wr_idx_q     <= wr_nx;
			rd_idx_q     <= rd_nx;
			mode_q       <= mode_nx;
			latch_byte_q <= latch_byte_nx;
			latch_full_q <= latch_full_nx;
		end
	end

	// ring memory, registered read at the head pointer
	always_ff @(posedge clk) begin
		if (cmd.exec && push) begin
			mem[wr_idx_q] <= {ev.tx_ninth_bit, ev.tx_byte};
		end
		rd_data_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((cmd.exec && !pop_hit) || cmd.load_pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && !pop_hit) begin
			res_q <= res_nx;
		end else if (cmd.load_pop) begin
			res_q <= pop_res;
		end
	end

	assign st.pop_hit  = pop_hit;
	assign st.out_full = res_valid_q;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	`ASSERT_NEXT(a_drop_holds_count, cmd.exec && ev.action == ACT_SEND && full, $stable(cnt_q), "dropped send changed the count")
	`ASSERT_NEXT(a_pop_emits, cmd.load_pop, res_valid_q && res_q.tx_valid, "popped word not presented")
	`ASSERT_ALWAYS(a_count_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "ring count above depth")

endmodule

@@ rtl/half_duplex_uart_tx_fifo_ctrl_unit.sv @@
// top level of the half-duplex serial link controller
// depends on hduart_pkg, hduart_ev_if, hduart_res_if, hduart_ctrl, hduart_dp

// Half-duplex single-wire serial link controller. Each event word on the
// events channel (send, transmit register empty, transmit complete, frame
// received, read key) produces exactly one result word on the results
// channel, carrying the popped transmit word, the drop flag, the key latch
// read-out, the line mode and the ring fill level after the event. Most
// events load the result register on acceptance; a transmit register
// empty event that pops the ring loads it from a read state, as the
// 64-entry ring memory has a registered read port and the popped word
// arrives in the cycle after; no event word is taken during the fetch.
// A result register sits between the two channels, so a new event is taken
// in the cycle its predecessor's result leaves. The ring needs no clearing
// after reset: entries are only read after they are written. After reset
// the line is in draining mode with the receiver off.
module half_duplex_uart_tx_fifo_ctrl_unit (
	input  logic      clk,
	input  logic      arst_n,
	hduart_ev_if.sink events,
	hduart_res_if.source results
);
	import hduart_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t    cmd;
	dp_status_t st;

	// controller: handshake and the pop fetch sequence
	hduart_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (events.valid),
		.ev_ready  (events.ready),
		.res_ready (results.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: ring, pointers, mode, key latch and result register
	hduart_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (events.data),
		.cmd       (cmd),
		.st        (st),
		.res_valid (results.valid),
		.res_ready (results.ready),
		.res       (results.data)
	);

endmodule

@@ tb/tb_half_duplex_uart_tx_fifo_ctrl_unit.sv @@
`timescale 1ns / 100ps
// testbench for half_duplex_uart_tx_fifo_ctrl_unit: a directed event table, then random link sessions
// every result word is checked against its table row or an in-bench model of ring, mode and key latch
// depends on hduart_pkg, hduart_ev_if, hduart_res_if and the rtl top level
module tb_half_duplex_uart_tx_fifo_ctrl_unit;
	import hduart_pkg::*;

	// action codes the block has no meaning for
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam int IDLE_MAX        = 18;
	localparam int HOLD_OFF_AT     = 120;    // result count at which the sink goes quiet
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WORD_TARGET     = 650;    // words that act on the link state
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int REPORT_MAX      = 10;

	typedef struct {
		ev_item_t  w;
		bit        typed;
		res_item_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	hduart_ev_if  events ();
	hduart_res_if results ();

	half_duplex_uart_tx_fifo_ctrl_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events),
		.results (results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// in-bench copy of the link state
	logic [8:0] ring_mem [FIFO_DEPTH];
	int         push_ptr;
	int         pop_ptr;
	int         held_words;
	mode_t      line_now;
	logic [7:0] key_latch;
	bit         key_present;

	res_item_t due_results [$];    // results still owed by the block, oldest first
	plan_row_t plan [$];

	int  src_idle_max;
	int  snk_idle_max;
	int  words_sent;
	int  words_acting;
	int  results_seen;
	int  mismatch_count;
	int  words_popped;
	int  sends_dropped;
	int  keys_read;
	int  cycle_count;
	bit  held_off;

	// apply one event word to the link state and return the result it owes
	// acted is set when the word is not simply ignored by the block
	function automatic res_item_t link_step(input ev_item_t w, output bit acted);
		res_item_t r;
		r = '0;
		acted = 1'b0;
		case (w.action)
			ACT_SEND: begin
				acted = 1'b1;
				// a full ring drops the word but the line still switches to sending
				if (held_words < FIFO_DEPTH) begin
					ring_mem[push_ptr] = {w.tx_ninth_bit, w.tx_byte};
					push_ptr = (push_ptr == FIFO_DEPTH - 1) ? 0 : push_ptr + 1;
					held_words++;
				end else begin
					r.send_dropped = 1'b1;
				end
				line_now = MODE_SEND;
			end
			ACT_TXE: begin
				// register empty only matters while sending
				if (line_now == MODE_SEND) begin
					acted = 1'b1;
					if (held_words != 0) begin
						r.tx_valid = 1'b1;
						r.tx_word = ring_mem[pop_ptr];
						pop_ptr = (pop_ptr == FIFO_DEPTH - 1) ? 0 : pop_ptr + 1;
						held_words--;
					end else begin
						line_now = MODE_DRAIN;
					end
				end
			end
			ACT_TXC: begin
				// last frame out, receiver back on
				if (line_now == MODE_DRAIN) begin
					acted = 1'b1;
					line_now = MODE_RECV;
				end
			end
			ACT_FRAME: begin
				// receiver off unless receiving; bad status or ninth bit rejects the frame
				if (line_now == MODE_RECV) begin
					acted = 1'b1;
					if ((w.rx_status & ERR_MASK) == '0 && !w.rx_ninth_bit) begin
						key_latch = w.rx_byte;
						key_present = 1'b1;
					end
				end
			end
			ACT_KEY: begin
				acted = 1'b1;
				if (key_present) begin
					r.key_valid = 1'b1;
					r.key_code = key_latch;
					key_latch = KEY_NONE;
					key_present = 1'b0;
				end
			end
			default: ;
		endcase
		r.line_mode = line_now;
		r.fill_level = FILL_W'(held_words);
		return r;
	endfunction

	function automatic ev_item_t mk_ev(input logic [2:0] act, input logic [7:0] txb,
			input logic tx9, input logic [7:0] rxb, input logic [7:0] rxs, input logic rx9);
		ev_item_t e;
		e.action = act;
		e.tx_byte = txb;
		e.tx_ninth_bit = tx9;
		e.rx_byte = rxb;
		e.rx_status = rxs;
		e.rx_ninth_bit = rx9;
		return e;
	endfunction

	function automatic res_item_t mk_res(input logic txv, input logic [8:0] word,
			input logic drop, input logic keyv, input logic [7:0] code, input mode_t mode,
			input int fill);
		res_item_t r;
		r.tx_valid = txv;
		r.tx_word = word;
		r.send_dropped = drop;
		r.key_valid = keyv;
		r.key_code = code;
		r.line_mode = mode;
		r.fill_level = FILL_W'(fill);
		return r;
	endfunction

	// given action, everything else random
	function automatic ev_item_t rand_fields(input logic [2:0] act);
		return mk_ev(act, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
	endfunction

	// received frame, mostly clean so the latch actually gets loaded
	function automatic ev_item_t rand_frame();
		ev_item_t e;
		e = rand_fields(ACT_FRAME);
		if ($urandom_range(0, 2) != 0)
			e.rx_status = e.rx_status & ~ERR_MASK;
		e.rx_ninth_bit = ($urandom_range(0, 5) == 0);
		return e;
	endfunction

	// idle phases: back to back, light gaps, or the full range
	function automatic int pick_idle_span();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 4;
			default: return IDLE_MAX;
		endcase
	endfunction

	task automatic add_row(input ev_item_t w, input bit typed, input res_item_t want);
		plan_row_t row;
		row.w = w;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	// hand one event word to the block and book the result it owes
	task automatic offer(input ev_item_t w, input bit typed, input res_item_t want);
		int        gap;
		bit        acted;
		res_item_t guess;
		gap = $urandom_range(0, src_idle_max);
		if (gap != 0) begin
			events.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		events.valid <= 1'b1;
		events.data <= w;
		do @(posedge clk); while (!events.ready);
		// word taken at this edge
		guess = link_step(w, acted);
		due_results.push_back(typed ? want : guess);
		words_sent++;
		if (acted)
			words_acting++;
		if (words_sent % 40 == 0)
			src_idle_max = pick_idle_span();
	endtask

	// event side: reset, directed table, random sessions, then drain and verdict
	initial begin : event_source
		int sess;
		int kind;
		int n;
		bit big;
		events.valid <= 1'b0;
		events.data <= '0;
		arst_n <= 1'b0;
		push_ptr = 0;
		pop_ptr = 0;
		held_words = 0;
		line_now = MODE_DRAIN;
		key_latch = KEY_NONE;
		key_present = 1'b0;
		src_idle_max = IDLE_MAX;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// line starts in draining with the receiver off
		add_row(mk_ev(ACT_KEY, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_DRAIN, 0));
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_DRAIN, 0));
		add_row(mk_ev(ACT_TXE, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_DRAIN, 0));
		add_row(mk_ev(ACT_TXC, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		// clean frame latched, then read back
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_KEY, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b1, 8'hFF, MODE_RECV, 0));
		// parity, overrun and frame error each reject
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h12, 8'h04, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h34, 8'h08, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h56, 8'h10, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		// ninth bit set, frame ignored
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h5A, 8'hE3, 1'b1), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		// non-error status bits pass, a zero byte still counts, second frame overwrites
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h00, 8'hE3, 1'b0), 1'b0, '0);
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'hA5, 8'h00, 1'b0), 1'b0, '0);
		add_row(mk_ev(ACT_KEY, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b0, '0);
		add_row(mk_ev(ACT_KEY, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		// spare codes and out-of-mode events leave everything alone
		add_row(mk_ev(ACT_SPARE_LO, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_TXC, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		add_row(mk_ev(ACT_TXE, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_RECV, 0));
		// two sends from receiving, frame ignored while sending, then pop both and drain
		add_row(mk_ev(ACT_SEND, 8'hFF, 1'b1, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_SEND, 1));
		add_row(mk_ev(ACT_SEND, 8'h00, 1'b0, 8'hFF, 8'hFF, 1'b1), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_SEND, 2));
		add_row(mk_ev(ACT_FRAME, 8'h00, 1'b0, 8'h77, 8'h00, 1'b0), 1'b0, '0);
		add_row(mk_ev(ACT_TXE, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b1, 9'h1FF, 1'b0, 1'b0, KEY_NONE, MODE_SEND, 1));
		add_row(mk_ev(ACT_TXE, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b1, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_SEND, 0));
		add_row(mk_ev(ACT_TXE, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0), 1'b1,
			mk_res(1'b0, 9'h000, 1'b0, 1'b0, KEY_NONE, MODE_DRAIN, 0));
		// send straight from draining
		add_row(mk_ev(ACT_SEND, 8'h3C, 1'b0, 8'h00, 8'h00, 1'b0), 1'b0, '0);

		foreach (plan[i])
			offer(plan[i].w, plan[i].typed, plan[i].want);

		// random sessions; the second one always overfills the ring
		sess = 0;
		while (words_acting < WORD_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind <= 4 || sess == 1) begin
				// transmit session: queue a burst, pop it out, drain, mostly hand the line back
				big = (sess == 1) || ($urandom_range(0, 15) == 0);
				n = big ? $urandom_range(66, 72) : $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					offer(rand_fields(ACT_SEND), 1'b0, '0);
					if (!big && $urandom_range(0, 5) == 0)
						offer(rand_fields(ACT_TXE), 1'b0, '0);
				end
				while (line_now == MODE_SEND) begin
					case ($urandom_range(0, 11))
						0: offer(rand_frame(), 1'b0, '0);
						1: offer(rand_fields(ACT_SEND), 1'b0, '0);
						default: offer(rand_fields(ACT_TXE), 1'b0, '0);
					endcase
				end
				if ($urandom_range(0, 3) != 0)
					offer(rand_fields(ACT_TXC), 1'b0, '0);
			end else if (kind <= 7) begin
				// receive session: get the line back first, then frames and key reads
				while (line_now == MODE_SEND)
					offer(rand_fields(ACT_TXE), 1'b0, '0);
				if (line_now == MODE_DRAIN)
					offer(rand_fields(ACT_TXC), 1'b0, '0);
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 2) == 0)
						offer(rand_fields(ACT_KEY), 1'b0, '0);
					else
						offer(rand_frame(), 1'b0, '0);
				end
			end else begin
				// noise: any code, any fields
				repeat ($urandom_range(1, 6))
					offer(rand_fields(3'($urandom_range(0, 7))), 1'b0, '0);
			end
			sess++;
		end
		events.valid <= 1'b0;

		// let the last results out, then a few more cycles for strays
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d event words (%0d acting on the link), checked %0d results",
			words_sent, words_acting, results_seen);
		$display("popped %0d words to the line, dropped %0d sends on a full ring, read %0d keys",
			words_popped, sends_dropped, keys_read);
		if (mismatch_count == 0 && due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off, compare against the oldest owed result
	initial begin : result_sink
		res_item_t got;
		res_item_t want;
		int        stall;
		results.ready <= 1'b0;
		snk_idle_max = IDLE_MAX;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held_off && results_seen >= HOLD_OFF_AT) begin
				// long quiet stretch so the block backs up into the event channel
				held_off = 1'b1;
				stall = HOLD_OFF_CYCLES;
			end else begin
				stall = $urandom_range(0, snk_idle_max);
			end
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
			got = results.data;
			results_seen++;
			if (got.tx_valid)
				words_popped++;
			if (got.send_dropped)
				sends_dropped++;
			if (got.key_valid)
				keys_read++;
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("result %0d with nothing owed: txv=%0b word=%h drop=%0b keyv=%0b key=%h mode=%0d fill=%0d",
						results_seen, got.tx_valid, got.tx_word, got.send_dropped,
						got.key_valid, got.key_code, got.line_mode, got.fill_level);
			end else begin
				want = due_results.pop_front();
				if (got.tx_valid !== want.tx_valid || got.tx_word !== want.tx_word ||
						got.send_dropped !== want.send_dropped ||
						got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
						got.line_mode !== want.line_mode ||
						got.fill_level !== want.fill_level) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("result %0d exp: txv=%0b word=%h drop=%0b keyv=%0b key=%h mode=%0d fill=%0d",
							results_seen, want.tx_valid, want.tx_word, want.send_dropped,
							want.key_valid, want.key_code, want.line_mode, want.fill_level);
						$display("result %0d got: txv=%0b word=%h drop=%0b keyv=%0b key=%h mode=%0d fill=%0d",
							results_seen, got.tx_valid, got.tx_word, got.send_dropped,
							got.key_valid, got.key_code, got.line_mode, got.fill_level);
					end
				end
			end
			if (results_seen % 40 == 0)
				snk_idle_max = pick_idle_span();
		end
	end

	// hard stop if the run hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/hduart_pkg.sv
rtl/hduart_ev_if.sv
rtl/hduart_res_if.sv
rtl/hduart_ctrl.sv
rtl/hduart_dp.sv
rtl/half_duplex_uart_tx_fifo_ctrl_unit.sv
tb/tb_half_duplex_uart_tx_fifo_ctrl_unit.sv
